// File: design/lstq_pkg.sv
`timescale 1ns / 1ps

package lstq_pkg;

  // sizing of the sensor bar
  localparam int NUM_SENSORS     = 15;
  localparam int ADC_BITS        = 12;
  localparam int STOP_COUNT_BITS = 8;
  localparam int IDX_BITS        = 4;
  localparam int CNT_BITS        = $clog2(NUM_SENSORS + 1);

  // sensors 5 and 9 count as neighbors across the center gap
  localparam int GAP_LEFT     = 5;
  localparam int GAP_RIGHT    = 9;
  localparam int EDGE_END_MIN = 4;
  localparam int EDGE_ANY_MIN = 5;

  // item kinds carried on the input tuser bit
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  // one request as it arrives
  typedef struct packed {
    logic                turning;
    logic                run_enable;
    logic [ADC_BITS-1:0] lower_threshold;
    logic [ADC_BITS-1:0] upper_threshold;
    logic [ADC_BITS-1:0] sample;
    logic [IDX_BITS-1:0] sensor_id;
    action_t             action;
  } item_t;

  // snapshot handed from the front to the back at a frame end
  typedef struct packed {
    logic                   turning;
    logic                   run_enable;
    logic [NUM_SENSORS-1:0] bits;
  } frame_t;

  // one finished frame result
  typedef struct packed {
    logic                       edge_hit;
    logic [STOP_COUNT_BITS-1:0] stop_count;
    logic                       gap_rejected;
    logic [CNT_BITS-1:0]        lit_count;
    logic [CNT_BITS-1:0]        track_count;
    logic [NUM_SENSORS-1:0]     track_mask;
    logic [NUM_SENSORS-1:0]     raw_bits;
  } result_t;

  // bit positions of the result fields on the output tdata
  localparam int OUT_RAW_LSB   = 0;
  localparam int OUT_MASK_LSB  = OUT_RAW_LSB + NUM_SENSORS;
  localparam int OUT_TCNT_LSB  = OUT_MASK_LSB + NUM_SENSORS;
  localparam int OUT_LCNT_LSB  = OUT_TCNT_LSB + CNT_BITS;
  localparam int OUT_GAP_BIT   = OUT_LCNT_LSB + CNT_BITS;
  localparam int OUT_STOP_LSB  = OUT_GAP_BIT + 1;
  localparam int OUT_EDGE_BIT  = OUT_STOP_LSB + STOP_COUNT_BITS;
  localparam int OUT_BITS      = OUT_EDGE_BIT + 1;
  localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // bit widths of the input tdata
  localparam int IN_BITS      = IDX_BITS + 3 * ADC_BITS + 2;
  localparam int IN_DATA_BITS = ((IN_BITS + 7) / 8) * 8;

endpackage

// File: design/lstq_front.sv
`timescale 1ns / 1ps

module lstq_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  lstq_pkg::item_t item,
  output logic            push,
  output lstq_pkg::frame_t frame
);
  import lstq_pkg::*;

  logic [ADC_BITS-1:0]    upper_table [NUM_SENSORS];
  logic [ADC_BITS-1:0]    lower_table [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] sensor_bits;
  logic [NUM_SENSORS-1:0] sensor_bits_next;
  logic                   in_range;
  logic                   is_last;
  logic                   set_hit;
  logic                   clr_hit;
  logic [ADC_BITS-1:0]    upper_sel;
  logic [ADC_BITS-1:0]    lower_sel;

  // index check and threshold lookup for the addressed sensor
  assign in_range  = {1'b0, item.sensor_id} < (IDX_BITS + 1)'(NUM_SENSORS);
  assign is_last   = {1'b0, item.sensor_id} == (IDX_BITS + 1)'(NUM_SENSORS - 1);
  assign upper_sel = in_range ? upper_table[item.sensor_id] : '0;
  assign lower_sel = in_range ? lower_table[item.sensor_id] : '0;
  assign set_hit   = item.sample > upper_sel;
  assign clr_hit   = item.sample < lower_sel;

  // hysteresis update, clear wins over set
  always_comb begin
    sensor_bits_next = sensor_bits;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (IDX_BITS'(i) == item.sensor_id) begin
        if (set_hit) sensor_bits_next[i] = 1'b1;
        if (clr_hit) sensor_bits_next[i] = 1'b0;
      end
    end
  end

  // threshold tables and on bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_bits <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        upper_table[i] <= '0;
        lower_table[i] <= '0;
      end
    end else if (take && in_range) begin
      if (item.action == ACT_LOAD) begin
        upper_table[item.sensor_id] <= item.upper_threshold;
        lower_table[item.sensor_id] <= item.lower_threshold;
      end else begin
        sensor_bits <= sensor_bits_next;
      end
    end
  end

  // a sample of the last sensor closes the frame
  assign push             = take && (item.action == ACT_SAMPLE) && is_last;
  assign frame.bits       = sensor_bits_next;
  assign frame.run_enable = item.run_enable;
  assign frame.turning    = item.turning;

endmodule

// File: design/lstq_queue.sv
`timescale 1ns / 1ps

module lstq_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lstq_pkg::frame_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output lstq_pkg::frame_t pop_data
);
  import lstq_pkg::*;

  frame_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: design/lstq_back.sv
`timescale 1ns / 1ps

module lstq_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  lstq_pkg::frame_t  frame,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lstq_pkg::result_t result
);
  import lstq_pkg::*;

  logic [NUM_SENSORS-1:0]     accepted_mask;
  logic [NUM_SENSORS-1:0]     mask_next;
  logic [STOP_COUNT_BITS-1:0] stop_run_count;
  logic [STOP_COUNT_BITS-1:0] stop_next;
  logic [CNT_BITS-1:0]        lit;
  logic [CNT_BITS-1:0]        track_cnt;
  logic                       broken;
  logic                       edge_flag;
  logic [NUM_SENSORS-1:0]     m;

  function automatic logic [CNT_BITS-1:0] pop_count(input logic [NUM_SENSORS-1:0] v);
    logic [CNT_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_SENSORS; i++) n = n + CNT_BITS'(v[i]);
    return n;
  endfunction

  assign m   = frame.bits;
  assign pop = in_valid && (!out_valid || out_ready);

  // a lit sensor with lit sensors below needs its lower neighbor lit,
  // or it is the right side of the center gap with only the left side below
  always_comb begin
    broken = 1'b0;
    for (int i = 1; i < NUM_SENSORS; i++) begin
      if (m[i] && (|(m & ((NUM_SENSORS)'(1) << i) - (NUM_SENSORS)'(1))) && !m[i-1]) begin
        if (!(i == GAP_RIGHT && m[GAP_LEFT] &&
              ((m >> (GAP_LEFT + 1)) & ((NUM_SENSORS)'(1) << (GAP_RIGHT - GAP_LEFT - 1))
               - (NUM_SENSORS)'(1)) == '0))
          broken = 1'b1;
      end
    end
  end

  // frame statistics and stop counter
  always_comb begin
    lit       = pop_count(m);
    mask_next = broken ? accepted_mask : m;
    track_cnt = pop_count(mask_next);
    if (frame.run_enable && !frame.turning && (&mask_next || mask_next == '0)) begin
      stop_next = (&stop_run_count) ? stop_run_count
                                    : stop_run_count + STOP_COUNT_BITS'(1);
    end else begin
      stop_next = '0;
    end
    edge_flag = ((m[0] || m[NUM_SENSORS-1]) && lit >= CNT_BITS'(EDGE_END_MIN)) ||
                lit >= CNT_BITS'(EDGE_ANY_MIN);
  end

  // qualifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_mask  <= '0;
      stop_run_count <= '0;
    end else if (pop) begin
      accepted_mask  <= mask_next;
      stop_run_count <= stop_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.raw_bits     <= m;
      result.track_mask   <= mask_next;
      result.track_count  <= track_cnt;
      result.lit_count    <= lit;
      result.gap_rejected <= broken;
      result.stop_count   <= stop_next;
      result.edge_hit     <= edge_flag;
    end
  end

endmodule

// File: design/line_sensor_track_qualifier.sv
`timescale 1ns / 1ps

// Line sensor track qualifier.
// Input stream (s_*): one request per cycle while the frame queue is not
// full. tuser selects a threshold load or an ADC sample; tdata carries the
// sensor id, sample and thresholds, plus the run switch and turn flags.
// Requests for indexes past the last sensor are taken and ignored.
// Output stream (m_*): one result per sample of the last sensor, carrying
// the raw on bits, the accepted track mask, both counts, the gap flag, the
// stop counter and the edge flag.
// Throughput: one request per cycle while the queue has room; the hysteresis
// update for the next request uses the front-stage table lookup and compare.
// Path: a frame-end sample is written into the two-entry frame queue when it
// is taken; the back stage then loads the output register from the queue
// head when that register is empty or being read, and raises m_tvalid.
// Stalls: when m_tready is low the result waits in the output register and
// later frames collect in the queue; s_tready drops only when the queue is
// full, so samples keep flowing during short stalls.
// Reset (rst, synchronous): thresholds, on bits, accepted mask and stop
// counter clear to zero, and the queue and output register empty.

module line_sensor_track_qualifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sensor_id, sample, upper_threshold, lower_threshold, run_enable, turning
  input  logic [lstq_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // action
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // raw_bits, track_mask, track_count, lit_count, gap_rejected, stop_count, edge_hit
  output logic [lstq_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import lstq_pkg::*;

  item_t   item;
  frame_t  push_frame;
  frame_t  head_frame;
  result_t result;
  logic    take;
  logic    push;
  logic    full;
  logic    not_empty;
  logic    pop;

  // unpack the request
  assign item.action          = action_t'(s_tuser);
  assign item.sensor_id       = s_tdata[IDX_BITS-1:0];
  assign item.sample          = s_tdata[IDX_BITS +: ADC_BITS];
  assign item.upper_threshold = s_tdata[IDX_BITS + ADC_BITS +: ADC_BITS];
  assign item.lower_threshold = s_tdata[IDX_BITS + 2 * ADC_BITS +: ADC_BITS];
  assign item.run_enable      = s_tdata[IDX_BITS + 3 * ADC_BITS];
  assign item.turning         = s_tdata[IDX_BITS + 3 * ADC_BITS + 1];

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  lstq_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (item),
    .push  (push),
    .frame (push_frame)
  );

  lstq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_frame),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (head_frame)
  );

  lstq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (not_empty),
    .frame     (head_frame),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  // pack the result
  assign m_tdata = OUT_DATA_BITS'(result);

endmodule

// File: design/lstq_checker.sv
`timescale 1ns / 1ps

module lstq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lstq_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import lstq_pkg::*;

  logic [NUM_SENSORS-1:0] raw;
  logic [NUM_SENSORS-1:0] mask;
  logic [CNT_BITS-1:0]    tcnt;
  logic [CNT_BITS-1:0]    lcnt;
  logic                   gap;

  assign raw  = m_tdata[OUT_RAW_LSB +: NUM_SENSORS];
  assign mask = m_tdata[OUT_MASK_LSB +: NUM_SENSORS];
  assign tcnt = m_tdata[OUT_TCNT_LSB +: CNT_BITS];
  assign lcnt = m_tdata[OUT_LCNT_LSB +: CNT_BITS];
  assign gap  = m_tdata[OUT_GAP_BIT];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // track count matches the accepted mask
  a_tcnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(mask) == int'(tcnt))
    else $error("track count mismatch");

  // lit count matches the raw bits
  a_lcnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(raw) == int'(lcnt))
    else $error("lit count mismatch");

  // a contiguous frame becomes the accepted mask
  a_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !gap |-> mask == raw)
    else $error("accepted mask differs from contiguous frame");

endmodule

bind line_sensor_track_qualifier lstq_checker u_lstq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
